@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is asserted.
`define ITC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ITC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg
// Types, protocol codes and checksum field offsets for the IPv4 transport
// checksum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itc_pkg;

    localparam logic [7:0] PROTO_IP   = 8'd0;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Checksum field offsets in 16-bit words (all byte offsets are even).
    localparam logic [14:0] HALF_OFF_IP   = 15'd5;
    localparam logic [14:0] HALF_OFF_ICMP = 15'd1;
    localparam logic [14:0] HALF_OFF_IGMP = 15'd1;
    localparam logic [14:0] HALF_OFF_TCP  = 15'd8;
    localparam logic [14:0] HALF_OFF_UDP  = 15'd3;

    // Six 16-bit pseudo-header terms need three extra bits.
    localparam int PSEUDO_W = 19;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
        logic [15:0] payload_bytes;
    } t_itc_in;

    typedef struct packed {
        logic [15:0] checksum_value;
        logic        unsupported_protocol;
    } t_itc_out;

    typedef struct packed {
        logic        supported;
        logic [14:0] half_offset;
    } t_itc_field;

    function automatic t_itc_field itc_checksum_field(input logic [7:0] proto);
        t_itc_field f;
        begin
            f.supported = 1'b1;
            case (proto)
                PROTO_IP:   f.half_offset = HALF_OFF_IP;
                PROTO_ICMP: f.half_offset = HALF_OFF_ICMP;
                PROTO_IGMP: f.half_offset = HALF_OFF_IGMP;
                PROTO_TCP:  f.half_offset = HALF_OFF_TCP;
                PROTO_UDP:  f.half_offset = HALF_OFF_UDP;
                default: begin
                    f.supported   = 1'b0;
                    f.half_offset = '0;
                end
            endcase
            return f;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/ipv4_transport_checksum.sv @@
// ----------------------------------------------------------------------------
// ipv4_transport_checksum
// Streaming Internet checksum over an IPv4 payload, one byte per request,
// with the checksum field masked and the pseudo-header added for TCP and UDP.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in  (itc_pkg::t_itc_in)
//   out      output     o_out_valid / i_out_ready o_out (itc_pkg::t_itc_out)
//
// One byte request is taken per cycle while o_in_ready is high; the running
// sum adder sets that rate. After its last byte is taken a result goes through
// sum capture, pseudo-header add, then fold and invert into the output register.
// Reset is synchronous and active low; it empties the pipeline and clears
// the running sum, byte position and held high byte.
// When the output is stalled the three result stages fill up, and o_in_ready
// drops only once all of them hold a result.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_transport_checksum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire itc_pkg::t_itc_in i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output itc_pkg::t_itc_out     o_out
);
    import itc_pkg::*;

    // Per-packet accumulation state.
    logic [31:0] r_sum;
    logic [15:0] r_pos;
    logic [7:0]  r_held;

    // Result pipeline: stage 1 holds the payload sum and the pseudo-header
    // sum, stage 2 their total, and the output register the checksum.
    logic                r_s1_valid;
    logic [31:0]         r_s1_sum;
    logic [PSEUDO_W-1:0] r_s1_pseudo;
    logic                r_s1_unsup;
    logic                r_s2_valid;
    logic [31:0]         r_s2_total;
    logic                r_s2_unsup;
    logic                r_out_valid;
    t_itc_out            r_out;

    t_itc_field          field;
    logic                excluded;
    logic [7:0]          data;
    logic [15:0]         word;
    logic [31:0]         word_sum;
    logic                add_pseudo;
    logic [PSEUDO_W-1:0] pseudo;
    logic                in_acc;
    logic                out_take;
    logic                out_free;
    logic                s2_move;
    logic                s2_free;
    logic                s1_move;
    logic                s1_free;
    logic [16:0]         fold1;
    logic [16:0]         fold2;

    // Each stage moves forward when the stage after it is empty or moving.
    assign out_take = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign s2_move  = r_s2_valid && out_free;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_move  = r_s1_valid && s2_free;
    assign s1_free  = !r_s1_valid || s2_free;

    assign o_in_ready  = s1_free;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        // Both bytes of the checksum field read as zero. The field offsets
        // are even, so one compare on the word index covers the pair.
        field    = itc_checksum_field(i_in.protocol_number);
        excluded = field.supported && (r_pos[15:1] == field.half_offset);
        data     = excluded ? 8'h00 : i_in.data_byte;

        // On an odd position this completes the held word; on an even last
        // byte it is the zero-padded final word. Either way the packet sum
        // on a last byte is the running sum plus this word.
        word     = r_pos[0] ? {r_held, data} : {data, 8'h00};
        word_sum = r_sum + {16'h0000, word};

        add_pseudo = (i_in.protocol_number == PROTO_TCP) ||
                     (i_in.protocol_number == PROTO_UDP);
        pseudo = (PSEUDO_W'(i_in.source_address[31:16]) +
                  PSEUDO_W'(i_in.source_address[15:0])) +
                 (PSEUDO_W'(i_in.dest_address[31:16]) +
                  PSEUDO_W'(i_in.dest_address[15:0])) +
                 (PSEUDO_W'(i_in.protocol_number) +
                  PSEUDO_W'(i_in.payload_bytes));

        // Two end-around folds bring the 32-bit total into 16 bits.
        fold1 = {1'b0, r_s2_total[31:16]} + {1'b0, r_s2_total[15:0]};
        fold2 = {1'b0, fold1[15:0]} + {16'h0000, fold1[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_pos       <= '0;
            r_held      <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                if (i_in.last_byte) begin
                    r_sum  <= '0;
                    r_pos  <= '0;
                    r_held <= '0;
                end else begin
                    r_pos <= r_pos + 16'd1;
                    if (r_pos[0]) begin
                        r_sum  <= word_sum;
                        r_held <= 8'h00;
                    end else begin
                        r_held <= data;
                    end
                end
            end

            if (in_acc && i_in.last_byte) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_move) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload registers; the valid flags above qualify them.
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_byte) begin
            r_s1_sum    <= word_sum;
            r_s1_pseudo <= add_pseudo ? pseudo : '0;
            r_s1_unsup  <= !field.supported;
        end
        if (s1_move) begin
            r_s2_total <= r_s1_sum + {{(32 - PSEUDO_W){1'b0}}, r_s1_pseudo};
            r_s2_unsup <= r_s1_unsup;
        end
        if (s2_move) begin
            r_out.checksum_value       <= r_s2_unsup ? 16'h0000 : ~fold2[15:0];
            r_out.unsupported_protocol <= r_s2_unsup;
        end
    end

`include "assert_macros.svh"

    `ITC_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> (!r_s1_valid && !r_s2_valid && !r_out_valid), "pipeline not empty after reset")
    `ITC_ASSERT(a_last_clears, i_clk, i_rst_n, (in_acc && i_in.last_byte) |=> (r_pos == 16'd0 && r_sum == 32'd0 && r_s1_valid), "packet state not cleared on last byte")
    `ITC_ASSERT(a_pos_steps, i_clk, i_rst_n, (in_acc && !i_in.last_byte) |=> (r_pos == $past(r_pos) + 16'd1), "byte position did not advance")
    `ITC_ASSERT(a_full_blocks, i_clk, i_rst_n, (r_s1_valid && r_s2_valid && r_out_valid && !i_out_ready) |-> !o_in_ready, "input ready while all result stages are stalled")

endmodule

`default_nettype wire
